// ===== hdl/base64_decoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// base64_decoder_unit_macros.svh
// Assertion macros shared by the base64 decoder modules.
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_UNIT_MACROS_SVH
`define BASE64_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define B64D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64d check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define B64D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64d check failed");

`endif

// ===== hdl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, character codes and decode functions of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  localparam logic [7:0] OFFSET_LO    = 8'd26;
  localparam logic [7:0] OFFSET_DIGIT = 8'd52;

  // Work item for the emit side: up to three bytes, how many, end of string.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       fin;
  } job_t;

  // Bit 6 flags a character outside the alphabet (pad included).
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      d = c - CHAR_UP_A;
      return {1'b0, d[5:0]};
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      d = c - CHAR_LO_A + OFFSET_LO;
      return {1'b0, d[5:0]};
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c - CHAR_ZERO + OFFSET_DIGIT;
      return {1'b0, d[5:0]};
    end else if (c == CHAR_PLUS) begin
      return {1'b0, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      return {1'b0, SEXTET_SLASH};
    end else if (c == CHAR_PAD) begin
      return {1'b1, 6'd0};
    end
    return {1'b1, 6'd0};
  endfunction

  function automatic logic [23:0] group_bytes(input logic [5:0] s0, input logic [5:0] s1,
                                              input logic [5:0] s2, input logic [5:0] s3);
    return {s0, s1[5:4], s1[3:0], s2[5:2], s2[1:0], s3};
  endfunction

endpackage

// ===== hdl/b64d_if.sv =====
// ----------------------------------------------------------------------------
// b64d_char_if / b64d_byte_if
// Valid/ready channels for characters in and decoded bytes out.
// ----------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_string;

  modport source (output valid, output char_in, output end_of_string, input ready);
  modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_of_run;
  logic       end_of_output;

  modport source (output valid, output data_byte, output has_byte, output last_of_run,
                  output end_of_output, input ready);
  modport sink (input valid, input data_byte, input has_byte, input last_of_run,
                input end_of_output, output ready);
endinterface

// ===== hdl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Map characters to sextets, hold the open group and issue emit jobs.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic           clk,
  input  logic           rst,
  b64d_char_if.sink      chars,
  input  logic           q_full,
  output logic           push,
  output b64d_pkg::job_t push_job
);
  import b64d_pkg::*;

  logic [5:0] held [3];
  logic [5:0] held_next [3];
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic       stopped;
  logic       stopped_next;
  logic [6:0] sv;
  logic [23:0] grp;
  logic       take;
  job_t       job;

  assign chars.ready = !q_full;
  assign take = chars.valid && chars.ready;

  always_comb begin
    held_next = held;
    held_count_next = held_count;
    stopped_next = stopped;
    job = '0;
    grp = '0;
    sv = sextet_of(chars.char_in);
    if (!stopped) begin
      if (sv[6]) begin
        stopped_next = 1'b1;
      end else if (held_count == 2'd3) begin
        grp = group_bytes(held[0], held[1], held[2], sv[5:0]);
        job.b0 = grp[23:16];
        job.b1 = grp[15:8];
        job.b2 = grp[7:0];
        job.cnt = 2'd3;
        held_count_next = 2'd0;
      end else begin
        held_next[held_count] = sv[5:0];
        held_count_next = held_count + 2'd1;
      end
    end
    if (chars.end_of_string) begin
      if (held_count_next >= 2'd2) begin
        grp = group_bytes(held_next[0], held_next[1], held_next[2], 6'd0);
        job.b0 = grp[23:16];
        job.b1 = grp[15:8];
        job.b2 = grp[7:0];
        job.cnt = held_count_next - 2'd1;
      end
      job.fin = 1'b1;
      held_count_next = 2'd0;
      stopped_next = 1'b0;
    end
  end

  assign push = take && (job.cnt != 2'd0 || job.fin);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      stopped <= 1'b0;
    end else if (take) begin
      held_count <= held_count_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= held_next;
    end
  end

endmodule

// ===== hdl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between the classify side and the emit side.
// ----------------------------------------------------------------------------
`include "base64_decoder_unit_macros.svh"

module b64d_queue #(
  parameter int Depth = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output b64d_pkg::job_t head
);
  import b64d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne = PtrW'(1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full = (count == FullCnt);
  assign nonempty = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && nonempty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrOne;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrOne;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CntOne;
        2'b01:   count <= count - CntOne;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  `B64D_ASSERT_NOW(a_no_overflow, push, !full)
  `B64D_ASSERT_NOW(a_count_range, 1'b1, count <= FullCnt)
  `B64D_ASSERT_NEXT(a_push_fills, do_push && !do_pop, nonempty)

endmodule

// ===== hdl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Walk each job and present its results one transfer at a time.
// ----------------------------------------------------------------------------
`include "base64_decoder_unit_macros.svh"

module b64d_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           nonempty,
  input  b64d_pkg::job_t head,
  output logic           pop,
  b64d_byte_if.source    bytes
);
  import b64d_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       last;
  logic       xfer;
  logic [7:0] sel;

  always_comb begin
    case (idx)
      2'd0:    sel = cur.b0;
      2'd1:    sel = cur.b1;
      default: sel = cur.b2;
    endcase
  end

  assign last = (cur.cnt == 2'd0) || (idx == cur.cnt - 2'd1);
  assign xfer = bytes.valid && bytes.ready;
  assign pop = nonempty && (!busy || (xfer && last));

  assign bytes.valid = busy;
  assign bytes.has_byte = (cur.cnt != 2'd0);
  assign bytes.data_byte = bytes.has_byte ? sel : 8'd0;
  assign bytes.last_of_run = last;
  assign bytes.end_of_output = last && cur.fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx <= 2'd0;
    end else if (xfer) begin
      if (last) begin
        busy <= 1'b0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  `B64D_ASSERT_NOW(a_empty_is_final, busy && !bytes.has_byte,
                   bytes.last_of_run && bytes.end_of_output)
  `B64D_ASSERT_NOW(a_end_on_last, bytes.valid && bytes.end_of_output, bytes.last_of_run)
  `B64D_ASSERT_NEXT(a_stall_holds, busy && !bytes.ready, busy && $stable(idx))

endmodule

// ===== hdl/base64_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64_decoder_unit
// Streaming base64 decoder: characters in, decoded bytes out.
// ----------------------------------------------------------------------------
// Channels: chars carries one character and an end-of-string flag per
// transfer; bytes carries one result per transfer (data_byte, has_byte,
// last_of_run, end_of_output).
// Throughput: one character per cycle while the job queue has room. A
// complete group or a flush becomes one job that the emit side shows as
// one to three transfers, so four characters give at most three results.
// Path: the job is written to the queue at the edge that transfers the
// character; the emit register loads it from the queue head once the emit
// side is idle or passes its last result, and shows its results from there.
// Reset: rst clears the group count, the stop flag, the queue and the emit
// side; held sextets are written before they are read.
// Stall: when bytes.ready is low the current result holds, the queue
// fills, and chars.ready drops once QueueDepth jobs are waiting.
// ----------------------------------------------------------------------------
module base64_decoder_unit #(
  parameter int QueueDepth = 4
) (
  input logic         clk,
  input logic         rst,
  b64d_char_if.sink   chars,
  b64d_byte_if.source bytes
);
  import b64d_pkg::*;

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic nonempty;
  job_t head;

  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .bytes    (bytes)
  );

endmodule
